>>> rtl/fvn_pkg.sv
// Shared constants, types and register indexes for the fractal value noise block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package fvn_pkg;

  // Field and register widths
  localparam int VOXEL_W = 10;
  localparam int STEP_W  = 24;
  localparam int CNT_W   = 4;
  localparam int OUT_W   = 8;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Defaults for top-level parameters
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int COORD_WIDTH_DEF = 10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd3;

  // Register reset values
  localparam logic [STEP_W-1:0] STEP_RST  = 24'd4096;
  localparam logic [CNT_W-1:0]  COUNT_RST = 4'd4;

  // Lattice hash constants
  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam logic [31:0] HASH_MUL_Z = 32'd113;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic [31:0] HASH_MASK  = 32'h7fffffff;

  // Smoothstep constant: 3 in Q2.16
  localparam logic [17:0] SMOOTH_K3 = 18'd196608;

  // Pipeline depths
  localparam int CELL_DEPTH = 12;
  localparam int DIV_STEPS  = 8;

  // Signed Q1.16 corner or blend value
  typedef logic signed [17:0] cv_t;
  localparam cv_t CV_ONE = 18'sd65536;

endpackage

>>> rtl/fvn_cell.sv
// One octave cell of the fractal value noise chain: scale, hash, trilinear blend, accumulate.
// Depends on fvn_pkg.
`timescale 1ns / 1ps
module fvn_cell import fvn_pkg::*; #(
  parameter int CW  = COORD_WIDTH_DEF,
  parameter int MO  = MAX_OCTAVES_DEF,
  parameter int OCT = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  logic [CW-1:0]              in_x,
  input  logic [CW-1:0]              in_y,
  input  logic [CW-1:0]              in_z,
  input  logic signed [MO+18:0]      in_sum,
  input  logic [$clog2(MO+1)-1:0]    oct_cnt,
  input  logic [STEP_W-1:0]          step_x,
  input  logic [STEP_W-1:0]          step_y,
  input  logic [STEP_W-1:0]          step_z,
  output logic                       out_vld,
  output logic [CW-1:0]              out_x,
  output logic [CW-1:0]              out_y,
  output logic [CW-1:0]              out_z,
  output logic signed [MO+18:0]      out_sum
);

  localparam int PW  = CW + STEP_W + OCT;
  localparam int SW  = MO + 19;
  localparam int CNW = $clog2(MO + 1);
  localparam int D   = CELL_DEPTH;

  function automatic logic signed [35:0] bprod(input cv_t a, input cv_t b,
                                               input logic [FRAC_W-1:0] s);
    logic signed [18:0] d;
    d = 19'(b) - 19'(a);
    return $signed({1'b0, s}) * d;
  endfunction

  function automatic cv_t bsum(input cv_t a, input logic signed [35:0] p);
    logic signed [18:0] r;
    r = 19'(a) + 19'(p >>> 16);
    return 18'(r);
  endfunction

  logic [2:0][CW-1:0]     crd_in;
  logic [2:0][STEP_W-1:0] stp;
  logic [PW-1:0]          pos [3];

  // control and carried payload
  logic                   vld_d [1:D];
  logic [2:0][CW-1:0]     crd_d [1:D];
  logic signed [SW-1:0]   sum_d [1:D-1];
  logic [2:0][FRAC_W-1:0] sm_d  [3:10];

  logic [2:0][7:0]        s1_cell;
  logic [2:0][FRAC_W-1:0] s1_frac;
  logic [2:0][31:0]       s2_ff;
  logic [2:0][17:0]       s2_k;
  logic [31:0]            s2_n  [8];
  logic [31:0]            s3_n  [8];
  logic [31:0]            s3_nn [8];
  logic [31:0]            s4_n  [8];
  logic [31:0]            s4_t  [8];
  logic [31:0]            s5_p  [8];
  cv_t                    s6_cv [8];
  cv_t                    s7_a  [4];
  logic signed [35:0]     s7_p  [4];
  cv_t                    s8_e  [4];
  cv_t                    s9_a  [2];
  logic signed [35:0]     s9_p  [2];
  cv_t                    s10_f [2];
  cv_t                    s11_a;
  logic signed [35:0]     s11_p;

  cv_t                    noise;
  logic signed [SW-1:0]   wn;
  logic                   act;

  assign crd_in = {in_z, in_y, in_x};
  assign stp    = {step_z, step_y, step_x};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = (PW'(crd_in[a]) * PW'(stp[a])) << OCT;
    end
  end

  assign noise = bsum(s11_a, s11_p);
  assign wn    = SW'(noise) <<< (MO - 1 - OCT);
  assign act   = oct_cnt > CNW'(OCT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= D; i++) vld_d[i] <= 1'b0;
    end else begin
      vld_d[1] <= in_vld;
      for (int i = 2; i <= D; i++) vld_d[i] <= vld_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    crd_d[1] <= crd_in;
    for (int i = 2; i <= D; i++) crd_d[i] <= crd_d[i-1];
    sum_d[1] <= in_sum;
    for (int i = 2; i <= D - 1; i++) sum_d[i] <= sum_d[i-1];
    for (int i = 4; i <= 10; i++) sm_d[i] <= sm_d[i-1];

    // stage 1: lattice cell and fraction per axis
    for (int a = 0; a < 3; a++) begin
      s1_cell[a] <= pos[a][23:16];
      s1_frac[a] <= pos[a][15:0];
    end
    // stage 2: smoothstep operands, corner hash seeds
    for (int a = 0; a < 3; a++) begin
      s2_ff[a] <= 32'(s1_frac[a]) * 32'(s1_frac[a]);
      s2_k[a]  <= SMOOTH_K3 - 18'({s1_frac[a], 1'b0});
    end
    for (int k = 0; k < 8; k++) begin
      logic [31:0] n;
      n = (32'(s1_cell[0]) + 32'(k % 2))
        + (32'(s1_cell[1]) + 32'((k / 2) % 2)) * HASH_MUL_Y
        + (32'(s1_cell[2]) + 32'(k / 4)) * HASH_MUL_Z;
      s2_n[k] <= n ^ (n << HASH_SHIFT);
    end
    // stage 3: smoothstep result, first hash product
    for (int a = 0; a < 3; a++) begin
      logic [49:0] sp;
      sp = 50'(s2_ff[a]) * 50'(s2_k[a]);
      sm_d[3][a] <= sp[47:32];
    end
    for (int k = 0; k < 8; k++) begin
      s3_nn[k] <= s2_n[k] * s2_n[k];
      s3_n[k]  <= s2_n[k];
    end
    // stages 4..6: finish the hash, map to Q1.16
    for (int k = 0; k < 8; k++) begin
      logic [31:0] m;
      s4_t[k] <= s3_nn[k] * HASH_C1 + HASH_C2;
      s4_n[k] <= s3_n[k];
      s5_p[k] <= s4_n[k] * s4_t[k];
      m = (s5_p[k] + HASH_C3) & HASH_MASK;
      s6_cv[k] <= CV_ONE - 18'(m[30:14]);
    end
    // stages 7..8: blend along x
    for (int j = 0; j < 4; j++) begin
      s7_a[j] <= s6_cv[2*j];
      s7_p[j] <= bprod(s6_cv[2*j], s6_cv[2*j+1], sm_d[6][0]);
      s8_e[j] <= bsum(s7_a[j], s7_p[j]);
    end
    // stages 9..10: blend along y
    for (int j = 0; j < 2; j++) begin
      s9_a[j]  <= s8_e[2*j];
      s9_p[j]  <= bprod(s8_e[2*j], s8_e[2*j+1], sm_d[8][1]);
      s10_f[j] <= bsum(s9_a[j], s9_p[j]);
    end
    // stages 11..12: blend along z, weight and accumulate
    s11_a   <= s10_f[0];
    s11_p   <= bprod(s10_f[0], s10_f[1], sm_d[10][2]);
    out_sum <= act ? sum_d[D-1] + wn : sum_d[D-1];
  end

  assign out_vld = vld_d[D];
  assign out_x   = crd_d[D][0];
  assign out_y   = crd_d[D][1];
  assign out_z   = crd_d[D][2];

endmodule

>>> rtl/fvn_div_step.sv
// One restoring-division cell: settles one quotient bit per stage.
// Depends on fvn_pkg.
`timescale 1ns / 1ps
module fvn_div_step import fvn_pkg::*; #(
  parameter int MO  = MAX_OCTAVES_DEF,
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [MO+7:0]     in_rem,
  input  logic [OUT_W-1:0]  in_quo,
  input  logic [MO-1:0]     dvs,
  output logic              out_vld,
  output logic [MO+7:0]     out_rem,
  output logic [OUT_W-1:0]  out_quo
);

  logic [MO+7:0] sub;
  logic          ge;

  assign sub = (MO+8)'(dvs) << BIT;
  assign ge  = in_rem >= sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_rem <= ge ? in_rem - sub : in_rem;
    out_quo <= in_quo | (OUT_W'(ge) << BIT);
  end

endmodule

>>> rtl/fractal_value_noise_3d.sv
// Top level of the 3-D fractal value noise generator: config registers, octave chain, normalizer.
// Depends on fvn_pkg, fvn_cell and fvn_div_step.
`timescale 1ns / 1ps
// Usage
//   Input: drive voxel_x/y/z and pulse start; a beat is taken at every edge with start
//   high and busy low. busy stays low, so a new coordinate can enter every cycle.
//   Output: done strobes for one cycle with noise_value; take it that cycle, since the
//   block has no way to hold a result back.
//   Config: cfg_we with cfg_index/cfg_data writes step_x, step_y, step_z or
//   octave_count; write only while no beat is in flight.
// Throughput and structure
//   One beat per cycle. Each octave cell is a 12-stage pipe (scale, smoothstep,
//   lattice hash, three blend pairs), then two normalize stages and an 8-stage
//   restoring divider, one quotient bit per stage.
//   Octaves beyond the clamped octave_count still flow through their cells but add nothing.
// Reset
//   rst clears all valid bits and loads the register defaults (steps 4096, four
//   octaves). There is no memory to clear, so the block is ready right after reset.
module fractal_value_noise_3d import fvn_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [VOXEL_W-1:0]   voxel_x,
  input  logic [VOXEL_W-1:0]   voxel_y,
  input  logic [VOXEL_W-1:0]   voxel_z,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]    cfg_data,
  output logic                 done,
  output logic [OUT_W-1:0]     noise_value
);

  localparam int MO  = MAX_OCTAVES;
  localparam int CW  = COORD_WIDTH;
  localparam int SW  = MO + 19;
  localparam int CNW = $clog2(MO + 1);
  localparam int LAT = MO * CELL_DEPTH + 2 + DIV_STEPS;

  // config registers
  logic [STEP_W-1:0] step_x, step_y, step_z;
  logic [CNT_W-1:0]  octave_count;

  logic [CNW-1:0]    cnt_eff;
  logic [MO:0]       w_tot;
  logic [MO:0]       dvs_full;
  logic [MO-1:0]     dvs;

  // chain wiring
  logic                 ch_vld [0:MO];
  logic [CW-1:0]        ch_x   [0:MO];
  logic [CW-1:0]        ch_y   [0:MO];
  logic [CW-1:0]        ch_z   [0:MO];
  logic signed [SW-1:0] ch_sum [0:MO];

  // normalize stages
  logic                 p1_vld, p2_vld;
  logic [MO+16:0]       p1_acc;
  logic [MO+24:0]       num;
  logic [MO+7:0]        p2_rem;

  // divider wiring
  logic                 dv_vld [0:DIV_STEPS];
  logic [MO+7:0]        dv_rem [0:DIV_STEPS];
  logic [OUT_W-1:0]     dv_quo [0:DIV_STEPS];

  // the pipe never stalls
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x       <= STEP_RST;
      step_y       <= STEP_RST;
      step_z       <= STEP_RST;
      octave_count <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_X:       step_x       <= cfg_data;
        REG_STEP_Y:       step_y       <= cfg_data;
        REG_STEP_Z:       step_z       <= cfg_data;
        REG_OCTAVE_COUNT: octave_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the octave count: zero means one, anything above the chain length saturates.
  always_comb begin
    if (octave_count == '0) begin
      cnt_eff = CNW'(1);
    end else if (int'(octave_count) > MO) begin
      cnt_eff = CNW'(MO);
    end else begin
      cnt_eff = CNW'(octave_count);
    end
  end

  // Total weight is 2^MO - 2^(MO-c); it factors as 2^(MO-c) * (2^c - 1), so the
  // normalize divide becomes a shift plus a divide by 2^c - 1.
  assign w_tot    = ((MO+1)'(1) << MO) - ((MO+1)'(1) << (MO - int'(cnt_eff)));
  assign dvs_full = ((MO+1)'(1) << cnt_eff) - (MO+1)'(1);
  assign dvs      = dvs_full[MO-1:0];

  assign ch_vld[0] = start & ~busy;
  assign ch_x[0]   = CW'(voxel_x);
  assign ch_y[0]   = CW'(voxel_y);
  assign ch_z[0]   = CW'(voxel_z);
  assign ch_sum[0] = '0;

  for (genvar o = 0; o < MO; o++) begin : g_oct
    fvn_cell #(.CW(CW), .MO(MO), .OCT(o)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (ch_vld[o]),
      .in_x    (ch_x[o]),
      .in_y    (ch_y[o]),
      .in_z    (ch_z[o]),
      .in_sum  (ch_sum[o]),
      .oct_cnt (cnt_eff),
      .step_x  (step_x),
      .step_y  (step_y),
      .step_z  (step_z),
      .out_vld (ch_vld[o+1]),
      .out_x   (ch_x[o+1]),
      .out_y   (ch_y[o+1]),
      .out_z   (ch_z[o+1]),
      .out_sum (ch_sum[o+1])
    );
  end

  // Shift the weighted sum from -W..W to 0..2W (in Q.16), then scale by 255 and
  // drop the power-of-two part of the divisor.
  assign num = ((MO+25)'(p1_acc) << 8) - (MO+25)'(p1_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else begin
      p1_vld <= ch_vld[MO];
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_acc <= (MO+17)'($signed({1'b0, ch_sum[MO]}) + $signed({3'b0, w_tot, 16'b0}));
    p2_rem <= (MO+8)'(num >> (MO - int'(cnt_eff) + 17));
  end

  assign dv_vld[0] = p2_vld;
  assign dv_rem[0] = p2_rem;
  assign dv_quo[0] = '0;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fvn_div_step #(.MO(MO), .BIT(DIV_STEPS - 1 - i)) u_div (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (dv_vld[i]),
      .in_rem  (dv_rem[i]),
      .in_quo  (dv_quo[i]),
      .dvs     (dvs),
      .out_vld (dv_vld[i+1]),
      .out_rem (dv_rem[i+1]),
      .out_quo (dv_quo[i+1])
    );
  end

  assign done        = dv_vld[DIV_STEPS];
  assign noise_value = dv_quo[DIV_STEPS];

`ifndef SYNTH
  // A result beat appears exactly the pipe latency after an accepted input beat.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without matching input beat");

  // The scaled dividend must give a quotient that fits the output byte.
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    p2_vld |-> (p2_rem < ((MO+8)'(dvs) << DIV_STEPS)))
    else $error("normalize dividend out of range");

  // The clamped octave count stays within the chain.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt_eff != '0) && (int'(cnt_eff) <= MO))
    else $error("effective octave count out of range");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for fractal_value_noise_3d: drives voxel beats and register writes.
// It checks every done strobe against its own fixed-point model or a typed expected value.
// Depends on fvn_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb;
  import fvn_pkg::*;

  localparam int OCTAVES   = MAX_OCTAVES_DEF;
  // 12 stages per octave cell, then normalize and divide
  localparam int LATENCY   = OCTAVES * 12 + 10;
  // Longest quiet stretch: pipeline fill plus a sender gap or a config pause
  localparam int WDOG_MAX  = 20 * LATENCY;
  localparam int RAND_SETS = 8;
  localparam int RAND_BEATS = 55;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [VOXEL_W-1:0]   voxel_x = '0;
  logic [VOXEL_W-1:0]   voxel_y = '0;
  logic [VOXEL_W-1:0]   voxel_z = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0]    cfg_data = '0;
  logic                 done;
  logic [OUT_W-1:0]     noise_value;

  fractal_value_noise_3d dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .noise_value(noise_value)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file, updated at the edge that writes it
  logic [STEP_W-1:0] step_shadow [3];
  logic [CNT_W-1:0]  count_shadow;

  // Noise samples still owed by the block, oldest first
  logic [OUT_W-1:0] noise_due [$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // Lattice corner: wrapping 32-bit hash mapped to signed Q1.16
  function automatic longint lattice_corner(bit [31:0] x, bit [31:0] y, bit [31:0] z);
    bit [31:0] n;
    bit [31:0] m;
    n = x + y * 32'd57 + z * 32'd113;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return 64'sd65536 - longint'(m >> 14);
  endfunction

  // a + floor(s*(b-a)/65536); an arithmetic shift floors toward minus infinity
  function automatic longint lerp_q16(longint a, longint b, longint s);
    return a + ((s * (b - a)) >>> 16);
  endfunction

  function automatic longint ease_q16(longint unsigned f);
    longint unsigned ff;
    ff = f * f;
    return longint'((ff * (64'd196608 - 2 * f)) >> 32);
  endfunction

  function automatic longint octave_value(bit [VOXEL_W-1:0] vx, bit [VOXEL_W-1:0] vy,
                                          bit [VOXEL_W-1:0] vz, int o);
    longint unsigned p [3];
    bit [31:0] ic [3];
    longint s [3];
    longint e00, e10, e01, e11, f0, f1;
    p[0] = (longint'(vx) * step_shadow[0]) << o;
    p[1] = (longint'(vy) * step_shadow[1]) << o;
    p[2] = (longint'(vz) * step_shadow[2]) << o;
    for (int a = 0; a < 3; a++) begin
      ic[a] = 32'((p[a] >> 16) & 64'd255);
      s[a]  = ease_q16(p[a] & 64'hffff);
    end
    e00 = lerp_q16(lattice_corner(ic[0], ic[1], ic[2]),
                   lattice_corner(ic[0] + 1, ic[1], ic[2]), s[0]);
    e10 = lerp_q16(lattice_corner(ic[0], ic[1] + 1, ic[2]),
                   lattice_corner(ic[0] + 1, ic[1] + 1, ic[2]), s[0]);
    e01 = lerp_q16(lattice_corner(ic[0], ic[1], ic[2] + 1),
                   lattice_corner(ic[0] + 1, ic[1], ic[2] + 1), s[0]);
    e11 = lerp_q16(lattice_corner(ic[0], ic[1] + 1, ic[2] + 1),
                   lattice_corner(ic[0] + 1, ic[1] + 1, ic[2] + 1), s[0]);
    f0 = lerp_q16(e00, e10, s[1]);
    f1 = lerp_q16(e01, e11, s[1]);
    return lerp_q16(f0, f1, s[2]);
  endfunction

  // Weighted octave sum, normalized to 0..255 and truncated
  function automatic logic [OUT_W-1:0] noise_sample(bit [VOXEL_W-1:0] vx,
                                                    bit [VOXEL_W-1:0] vy,
                                                    bit [VOXEL_W-1:0] vz);
    int cnt;
    longint acc, wsum, w;
    longint unsigned q;
    cnt = int'(count_shadow);
    acc = 0;
    wsum = 0;
    // zero octaves means one; too many saturates
    if (cnt == 0) cnt = 1;
    if (cnt > OCTAVES) cnt = OCTAVES;
    for (int o = 0; o < cnt; o++) begin
      w = 64'sd1 << (OCTAVES - 1 - o);
      acc += octave_value(vx, vy, vz, o) * w;
      wsum += w;
    end
    q = longint'((acc + wsum * 65536) * 255) / longint'(wsum * 131072);
    if (q > 255) q = 255;
    return q[OUT_W-1:0];
  endfunction

  // Append one owed sample at the tail of the queue
  task automatic queue_sample(logic [OUT_W-1:0] val);
    noise_due.insert(noise_due.size(), val);
  endtask

  // Result checker: done is sampled just before the edge that takes it
  always @(posedge clk) begin
    if (!rst && done) begin
      if (noise_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result noise_value=%0d", noise_value);
      end else begin
        logic [OUT_W-1:0] want;
        want = noise_due.pop_front();
        if (want !== noise_value) begin
          errors++;
          if (errors <= 10)
            $display("noise_value mismatch: expected %0d, got %0d", want, noise_value);
        end
      end
    end
  end

  // Watchdog: any beat taken or result seen counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Write one register at the next edge and mirror the masked value;
  // the caller drops the write enable after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_STEP_X:       step_shadow[0] = val;
      REG_STEP_Y:       step_shadow[1] = val;
      REG_STEP_Z:       step_shadow[2] = val;
      REG_OCTAVE_COUNT: count_shadow = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Drain all samples in flight, then let the pipe settle before touching registers
  task automatic drain;
    while (noise_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy,
                             logic [STEP_W-1:0] sz, logic [STEP_W-1:0] cnt);
    drain();
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_STEP_Z, sz);
    write_reg(REG_OCTAVE_COUNT, cnt);
    cfg_we <= 1'b0;
  endtask

  // Present one beat, hold it until taken, then maybe drop start for a gap.
  // want < 0 means use the predictor.
  task automatic send_beat(logic [VOXEL_W-1:0] x, logic [VOXEL_W-1:0] y,
                           logic [VOXEL_W-1:0] z, int want);
    int gap;
    start <= 1'b1;
    voxel_x <= x;
    voxel_y <= y;
    voxel_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (want >= 0) queue_sample(want[OUT_W-1:0]);
    else queue_sample(noise_sample(x, y, z));
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Directed rows; want is typed only where it follows directly from the setup
  typedef struct {
    logic [VOXEL_W-1:0] x;
    logic [VOXEL_W-1:0] y;
    logic [VOXEL_W-1:0] z;
    int want;
  } voxel_row_t;

  voxel_row_t default_rows [] = '{
    '{10'd0, 10'd0, 10'd0, -1},       '{10'd1023, 10'd1023, 10'd1023, -1},
    '{10'd1023, 10'd0, 10'd0, -1},    '{10'd0, 10'd1023, 10'd0, -1},
    '{10'd0, 10'd0, 10'd1023, -1},    '{10'd1, 10'd1, 10'd1, -1},
    '{10'd16, 10'd16, 10'd16, -1},    '{10'd8, 10'd24, 10'd40, -1},
    '{10'd512, 10'd256, 10'd128, -1}, '{10'h2aa, 10'h155, 10'h2aa, -1},
    '{10'h155, 10'h2aa, 10'h155, -1}, '{10'd511, 10'd767, 10'd1000, -1}
  };

  // With every step zero all octaves sit on corner (0,0,0): hash -18467 -> 91
  voxel_row_t flat_rows [] = '{
    '{10'd0, 10'd0, 10'd0, 91},       '{10'd1023, 10'd1023, 10'd1023, 91},
    '{10'h2aa, 10'h155, 10'd7, 91}
  };

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 3))
      0: return STEP_W'($urandom_range(0, 24'hffffff));
      1: return STEP_W'($urandom_range(0, 65535));
      2: return $urandom_range(0, 1) ? 24'hffffff : 24'd0;
      default: return STEP_RST;
    endcase
  endfunction

  initial begin
    step_shadow[0] = STEP_RST;
    step_shadow[1] = STEP_RST;
    step_shadow[2] = STEP_RST;
    count_shadow = COUNT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults straight out of reset
    foreach (default_rows[i])
      send_beat(default_rows[i].x, default_rows[i].y, default_rows[i].z, default_rows[i].want);

    start <= 1'b0;
    load_config(24'd0, 24'd0, 24'd0, 24'd8);
    foreach (flat_rows[i])
      send_beat(flat_rows[i].x, flat_rows[i].y, flat_rows[i].z, flat_rows[i].want);

    // Largest steps, zero octave count (acts as one) and a count above the maximum
    start <= 1'b0;
    load_config(24'hffffff, 24'hffffff, 24'hffffff, 24'd0);
    send_beat(10'd1023, 10'd1023, 10'd1023, -1);
    send_beat(10'd3, 10'd5, 10'd7, -1);
    start <= 1'b0;
    load_config(24'd65536, 24'd32768, 24'd1, 24'hfffff9);
    send_beat(10'd1023, 10'd1, 10'd1023, -1);
    send_beat(10'd100, 10'd200, 10'd300, -1);

    // Random register sets, each followed by a stream of random voxels
    for (int set = 0; set < RAND_SETS; set++) begin
      start <= 1'b0;
      load_config(pick_step(), pick_step(), pick_step(),
                  (set == 0) ? 24'd1 : (set == 1) ? 24'd15 :
                  STEP_W'($urandom_range(0, 24'hffffff)));
      gaps_on = (set % 3) != 2;
      for (int k = 0; k < RAND_BEATS; k++)
        send_beat(VOXEL_W'($urandom_range(0, 1023)), VOXEL_W'($urandom_range(0, 1023)),
                  VOXEL_W'($urandom_range(0, 1023)), -1);
    end

    start <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
